@@ hw/rtl/au_pkg.sv @@
// Shared types, codes and helpers for the AU stream decoder.
// Used by the front, command queue, back and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package au_pkg;

    localparam int C_QUEUE_DEPTH = 2;

    localparam logic [14:0] C_HEADER_LIMIT_RESET = 15'd32767;
    localparam logic [31:0] C_HEADER_BYTES       = 32'd24;

    // ".snd" and ".sd\0" as they arrive, first byte in the top byte
    localparam logic [31:0] C_MAGIC_SND = 32'h2E736E64;
    localparam logic [31:0] C_MAGIC_SD  = 32'h2E736400;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_INFO   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ENC_ULAW  = 2'd0;
    localparam logic [1:0] ENC_PCM8  = 2'd1;
    localparam logic [1:0] ENC_PCM16 = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_ENCODING = 3'd2;
    localparam logic [2:0] ERR_CHANNELS = 3'd3;
    localparam logic [2:0] ERR_OFFSET   = 3'd4;

    typedef enum logic [2:0] {
        OP_ULAW,
        OP_PCM8,
        OP_PCM16,
        OP_INFO,
        OP_ERROR
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic [7:0]  hi;
        logic        channel;
        logic [1:0]  encoding;
        logic [31:0] rate;
        logic [1:0]  channels;
        logic [31:0] size;
        logic [31:0] offset;
        logic [2:0]  err;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // G.711 u-law expansion
    function automatic logic [15:0] ulaw_expand(input logic [7:0] b);
        logic [7:0]  u;
        logic [15:0] t;
        u = ~b;
        t = (16'({u[3:0], 3'b000}) + 16'h0084) << u[6:4];
        if (u[7]) begin
            ulaw_expand = 16'h0084 - t;
        end else begin
            ulaw_expand = t - 16'h0084;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/au_stream_if.sv @@
// Channel interfaces of the AU stream decoder: byte input, result output
// and header limit write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface au_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface au_result_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  kind;
    logic signed [15:0] sample;
    logic               channel;
    logic        [1:0]  encoding;
    logic        [31:0] sample_rate;
    logic        [1:0]  channels;
    logic signed [31:0] frame_count;
    logic        [31:0] data_offset;
    logic        [2:0]  error_code;
    modport source (output valid, kind, sample, channel, encoding, sample_rate,
                    channels, frame_count, data_offset, error_code, input ready);
    modport sink   (input valid, kind, sample, channel, encoding, sample_rate,
                    channels, frame_count, data_offset, error_code, output ready);
endinterface

interface au_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] header_limit;
    modport source (output valid, header_limit, input ready);
    modport sink   (input valid, header_limit, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/au_audio_stream_decoder.sv @@
// Top level of the AU stream decoder: header limit register, front part,
// command queue and back part. Depends on au_pkg and au_stream_if.
//
// Usage:
//   i_in takes one byte of an AU file per transfer, with in_last on the
//   final byte; it accepts a byte every cycle while the command queue
//   has room. o_out gives one result per transfer: a header info or
//   header error after the header, then one 16-bit sample per u-law or
//   8-bit byte, or per byte pair for 16-bit data. Bytes of the skip area
//   and bytes after an error give no result.
//   i_cfg writes header_limit and is always ready; write it only while idle.
//   Timing: the command of a byte is written into the command queue as the
//   byte transfers, and moves into the result register once that register
//   is free. Throughput: one byte per cycle while the command queue has
//   room.
//   A stalled receiver holds the result register; the queue absorbs up to
//   QUEUE_DEPTH commands, then i_in.ready drops until o_out moves again.
//   Reset clears the parser, the queue and the result valid, and sets
//   header_limit to 32767. A transfer with in_last returns the parser to
//   the header after that byte; header_limit keeps its value.
`timescale 1ns / 1ps
`default_nettype none

module au_audio_stream_decoder import au_pkg::*; #(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    au_byte_if.sink     i_in,
    au_cfg_if.sink      i_cfg,
    au_result_if.source o_out
);

    logic [14:0]   r_header_limit;
    logic          push;
    logic          pop;
    t_cmd          front_cmd;
    t_cmd          head_cmd;
    t_queue_status q_status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_limit <= C_HEADER_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_header_limit <= i_cfg.header_limit;
        end
    end

    au_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_header_limit (r_header_limit),
        .i_queue_full   (q_status.full),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    au_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    au_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_valid (!q_status.empty),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ hw/rtl/au_front.sv @@
// Front part: accepts bytes, parses the header, tracks skip and sample
// assembly, and pushes commands. Depends on au_pkg and au_byte_if.
`timescale 1ns / 1ps
`default_nettype none

module au_front import au_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    au_byte_if.sink     i_in,
    input  wire  [14:0] i_header_limit,
    input  wire         i_queue_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_DATA,
        PH_IDLE
    } t_phase;

    localparam logic [2:0] FLD_MAGIC    = 3'd0;
    localparam logic [2:0] FLD_OFFSET   = 3'd1;
    localparam logic [2:0] FLD_SIZE     = 3'd2;
    localparam logic [2:0] FLD_ENCODING = 3'd3;
    localparam logic [2:0] FLD_RATE     = 3'd4;

    t_phase      r_phase,  n_phase;
    logic [14:0] r_pos,    n_pos;
    logic [23:0] r_shift,  n_shift;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_size,   n_size;
    logic [1:0]  r_enc,    n_enc;
    logic [31:0] r_rate,   n_rate;
    logic        r_stereo, n_stereo;
    logic        r_toggle, n_toggle;
    logic [7:0]  r_hi,     n_hi;
    logic        r_odd,    n_odd;

    logic        fire;
    logic [31:0] word;
    logic [14:0] pos_inc;

    assign i_in.ready = !i_queue_full;
    assign fire       = i_in.valid && !i_queue_full;
    assign word       = {r_shift, i_in.in_byte};
    assign pos_inc    = r_pos + 15'd1;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_shift  = r_shift;
        n_offset = r_offset;
        n_size   = r_size;
        n_enc    = r_enc;
        n_rate   = r_rate;
        n_stereo = r_stereo;
        n_toggle = r_toggle;
        n_hi     = r_hi;
        n_odd    = r_odd;
        o_push   = 1'b0;
        o_cmd    = '0;
        o_cmd.op = OP_ERROR;

        if (fire) begin
            case (r_phase)
                PH_HEADER: begin
                    n_shift = word[23:0];
                    n_pos   = pos_inc;
                    if (r_pos[1:0] == 2'd3) begin
                        case (r_pos[4:2])
                            FLD_MAGIC: begin
                                if (word != C_MAGIC_SND && word != C_MAGIC_SD) begin
                                    o_push    = 1'b1;
                                    o_cmd.err = ERR_MAGIC;
                                    n_phase   = PH_IDLE;
                                end
                            end
                            FLD_OFFSET: begin
                                n_offset = word;
                                if (word < C_HEADER_BYTES || word > {17'd0, i_header_limit})
                                begin
                                    o_push    = 1'b1;
                                    o_cmd.err = ERR_OFFSET;
                                    n_phase   = PH_IDLE;
                                end
                            end
                            FLD_SIZE: begin
                                n_size = word;
                            end
                            FLD_ENCODING: begin
                                if (word == 32'd1) begin
                                    n_enc = ENC_ULAW;
                                end else if (word == 32'd2) begin
                                    n_enc = ENC_PCM8;
                                end else if (word == 32'd3) begin
                                    n_enc = ENC_PCM16;
                                end else begin
                                    o_push    = 1'b1;
                                    o_cmd.err = ERR_ENCODING;
                                    n_phase   = PH_IDLE;
                                end
                            end
                            FLD_RATE: begin
                                n_rate = word;
                            end
                            default: begin
                                o_push = 1'b1;
                                if (word != 32'd1 && word != 32'd2) begin
                                    o_cmd.err = ERR_CHANNELS;
                                    n_phase   = PH_IDLE;
                                end else begin
                                    n_stereo       = (word == 32'd2);
                                    o_cmd.op       = OP_INFO;
                                    o_cmd.encoding = r_enc;
                                    o_cmd.rate     = r_rate;
                                    o_cmd.channels = word[1:0];
                                    o_cmd.size     = r_size;
                                    o_cmd.offset   = r_offset;
                                    n_phase = (r_offset <= C_HEADER_BYTES) ? PH_DATA : PH_SKIP;
                                end
                            end
                        endcase
                    end
                end
                PH_SKIP: begin
                    n_pos = pos_inc;
                    if ({17'd0, pos_inc} >= r_offset) begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    o_cmd.data    = i_in.in_byte;
                    o_cmd.hi      = r_hi;
                    o_cmd.channel = r_toggle;
                    case (r_enc)
                        ENC_ULAW: begin
                            o_push   = 1'b1;
                            o_cmd.op = OP_ULAW;
                        end
                        ENC_PCM8: begin
                            o_push   = 1'b1;
                            o_cmd.op = OP_PCM8;
                        end
                        default: begin
                            if (!r_odd) begin
                                n_hi  = i_in.in_byte;
                                n_odd = 1'b1;
                            end else begin
                                n_odd    = 1'b0;
                                o_push   = 1'b1;
                                o_cmd.op = OP_PCM16;
                            end
                        end
                    endcase
                    if (o_push) begin
                        n_toggle = r_stereo ? ~r_toggle : 1'b0;
                    end
                end
                default: begin
                end
            endcase

            if (i_in.in_last) begin
                n_phase  = PH_HEADER;
                n_pos    = '0;
                n_shift  = '0;
                n_offset = '0;
                n_size   = '0;
                n_enc    = ENC_ULAW;
                n_rate   = '0;
                n_stereo = 1'b0;
                n_toggle = 1'b0;
                n_hi     = '0;
                n_odd    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_shift  <= '0;
            r_offset <= '0;
            r_size   <= '0;
            r_enc    <= ENC_ULAW;
            r_rate   <= '0;
            r_stereo <= 1'b0;
            r_toggle <= 1'b0;
            r_hi     <= '0;
            r_odd    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_shift  <= n_shift;
            r_offset <= n_offset;
            r_size   <= n_size;
            r_enc    <= n_enc;
            r_rate   <= n_rate;
            r_stereo <= n_stereo;
            r_toggle <= n_toggle;
            r_hi     <= n_hi;
            r_odd    <= n_odd;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/au_cmd_queue.sv @@
// Short command queue between the front and back parts.
// Depends on au_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module au_cmd_queue import au_pkg::*; #(
    parameter int DEPTH = C_QUEUE_DEPTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  t_cmd          i_cmd,
    input  wire           i_pop,
    output t_cmd          o_cmd,
    output t_queue_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/au_back.sv @@
// Back part: expands samples, computes the frame count and holds the
// result register. Depends on au_pkg and au_result_if.
`timescale 1ns / 1ps
`default_nettype none

module au_back import au_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    input  wire         i_cmd_valid,
    output logic        o_pop,
    au_result_if.source o_out
);

    logic               r_valid;
    logic        [1:0]  r_kind,     n_kind;
    logic signed [15:0] r_sample,   n_sample;
    logic               r_channel,  n_channel;
    logic        [1:0]  r_encoding, n_encoding;
    logic        [31:0] r_rate,     n_rate;
    logic        [1:0]  r_channels, n_channels;
    logic signed [31:0] r_frames,   n_frames;
    logic        [31:0] r_offset,   n_offset;
    logic        [2:0]  r_err,      n_err;

    logic [1:0]  shift;
    logic [31:0] bias;
    logic [31:0] biased;

    assign o_pop = i_cmd_valid && (!r_valid || o_out.ready);

    // truncate toward zero: bias negative sizes before the shift
    assign shift  = 2'(i_cmd.encoding == ENC_PCM16) + 2'(i_cmd.channels == 2'd2);
    assign bias   = i_cmd.size[31] ? ((32'd1 << shift) - 32'd1) : 32'd0;
    assign biased = i_cmd.size + bias;

    always_comb begin
        n_kind     = KIND_SAMPLE;
        n_sample   = '0;
        n_channel  = 1'b0;
        n_encoding = '0;
        n_rate     = '0;
        n_channels = '0;
        n_frames   = '0;
        n_offset   = '0;
        n_err      = ERR_NONE;
        case (i_cmd.op)
            OP_ULAW: begin
                n_sample  = ulaw_expand(i_cmd.data);
                n_channel = i_cmd.channel;
            end
            OP_PCM8: begin
                n_sample  = {i_cmd.data, 8'h00};
                n_channel = i_cmd.channel;
            end
            OP_PCM16: begin
                n_sample  = {i_cmd.hi, i_cmd.data};
                n_channel = i_cmd.channel;
            end
            OP_INFO: begin
                n_kind     = KIND_INFO;
                n_encoding = i_cmd.encoding;
                n_rate     = i_cmd.rate;
                n_channels = i_cmd.channels;
                n_frames   = $signed(biased) >>> shift;
                n_offset   = i_cmd.offset;
            end
            OP_ERROR: begin
                n_kind = KIND_ERROR;
                n_err  = i_cmd.err;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind     <= n_kind;
            r_sample   <= n_sample;
            r_channel  <= n_channel;
            r_encoding <= n_encoding;
            r_rate     <= n_rate;
            r_channels <= n_channels;
            r_frames   <= n_frames;
            r_offset   <= n_offset;
            r_err      <= n_err;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_kind;
    assign o_out.sample      = r_sample;
    assign o_out.channel     = r_channel;
    assign o_out.encoding    = r_encoding;
    assign o_out.sample_rate = r_rate;
    assign o_out.channels    = r_channels;
    assign o_out.frame_count = r_frames;
    assign o_out.data_offset = r_offset;
    assign o_out.error_code  = r_err;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for au_audio_stream_decoder: directed and random AU streams are
// fed byte by byte and every result is checked against a local decoder model.
// Depends on au_pkg, au_stream_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
    import au_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 720;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;

    // encoding codes as they appear in the AU header
    localparam logic [31:0] AU_ULAW_CODE  = 32'd1;
    localparam logic [31:0] AU_PCM8_CODE  = 32'd2;
    localparam logic [31:0] AU_PCM16_CODE = 32'd3;

    typedef enum logic [1:0] {PS_HEADER, PS_SKIP, PS_DATA, PS_IDLE} t_parse_state;

    typedef struct {
        logic        [1:0]  kind;
        logic signed [15:0] sample;
        logic               channel;
        logic        [1:0]  encoding;
        logic        [31:0] sample_rate;
        logic        [1:0]  channels;
        logic signed [31:0] frame_count;
        logic        [31:0] data_offset;
        logic        [2:0]  error_code;
    } t_au_result;

    logic i_clk;
    logic i_rst_n;

    au_byte_if   in_if();
    au_cfg_if    cfg_if();
    au_result_if out_if();

    au_audio_stream_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    t_au_result expected_results[$];
    logic [7:0] stream_bytes[$];
    int         mismatches;
    int         bytes_sent;
    bit         src_idle_en;
    bit         sink_idle_en;
    bit         long_hold_req;

    // decoder model state
    logic [14:0]  limit_q;
    t_parse_state ps_q;
    logic [14:0]  pos_q;
    logic [31:0]  shift_q;
    logic [31:0]  offset_q;
    logic [31:0]  size_q;
    logic [31:0]  rate_q;
    logic [1:0]   enc_q;
    logic         stereo_q;
    logic         toggle_q;
    logic         odd_q;
    logic [7:0]   hi_q;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_decoder_state;
        ps_q     = PS_HEADER;
        pos_q    = '0;
        shift_q  = '0;
        offset_q = '0;
        size_q   = '0;
        rate_q   = '0;
        enc_q    = '0;
        stereo_q = 1'b0;
        toggle_q = 1'b0;
        odd_q    = 1'b0;
        hi_q     = '0;
    endtask

    function automatic logic [15:0] expand_ulaw(input logic [7:0] b);
        logic [7:0]  u;
        logic [31:0] t;
        logic [31:0] v;
        u = ~b;
        t = (({28'd0, u[3:0]} << 3) + 32'h84) << u[6:4];
        v = u[7] ? (32'h84 - t) : (t - 32'h84);
        return v[15:0];
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic last);
        t_au_result  r;
        bit          have;
        logic [2:0]  err;
        logic [14:0] pos;
        logic [31:0] word;
        longint      sz;
        r    = '{default: '0};
        have = 0;
        err  = ERR_NONE;
        case (ps_q)
            PS_HEADER: begin
                pos     = pos_q;
                shift_q = {shift_q[23:0], b};
                pos_q   = pos_q + 15'd1;
                if (pos[1:0] == 2'd3) begin
                    word = shift_q;
                    case (pos[14:2])
                        13'd0: begin
                            if (word != C_MAGIC_SND && word != C_MAGIC_SD) err = ERR_MAGIC;
                        end
                        13'd1: begin
                            offset_q = word;
                            if (word < C_HEADER_BYTES || word > {17'd0, limit_q}) err = ERR_OFFSET;
                        end
                        13'd2: size_q = word;
                        13'd3: begin
                            if (word == AU_ULAW_CODE) enc_q = ENC_ULAW;
                            else if (word == AU_PCM8_CODE) enc_q = ENC_PCM8;
                            else if (word == AU_PCM16_CODE) enc_q = ENC_PCM16;
                            else err = ERR_ENCODING;
                        end
                        13'd4: rate_q = word;
                        default: begin
                            if (word != 32'd1 && word != 32'd2) begin
                                err = ERR_CHANNELS;
                            end else begin
                                stereo_q = (word == 32'd2);
                                sz = $signed(size_q);
                                if (enc_q == ENC_PCM16) sz = sz / 2;
                                if (stereo_q) sz = sz / 2;
                                r.kind        = KIND_INFO;
                                r.encoding    = enc_q;
                                r.sample_rate = rate_q;
                                r.channels    = word[1:0];
                                r.frame_count = sz[31:0];
                                r.data_offset = offset_q;
                                have = 1;
                                ps_q = (offset_q <= C_HEADER_BYTES) ? PS_DATA : PS_SKIP;
                            end
                        end
                    endcase
                end
            end
            PS_SKIP: begin
                pos_q = pos_q + 15'd1;
                if ({17'd0, pos_q} >= offset_q) ps_q = PS_DATA;
            end
            PS_DATA: begin
                case (enc_q)
                    ENC_ULAW: begin
                        r.sample = expand_ulaw(b);
                        have = 1;
                    end
                    ENC_PCM8: begin
                        r.sample = {b, 8'h00};
                        have = 1;
                    end
                    default: begin
                        if (!odd_q) begin
                            hi_q  = b;
                            odd_q = 1'b1;
                        end else begin
                            odd_q    = 1'b0;
                            r.sample = {hi_q, b};
                            have = 1;
                        end
                    end
                endcase
                if (have) begin
                    r.kind    = KIND_SAMPLE;
                    r.channel = toggle_q;
                    toggle_q  = stereo_q ? ~toggle_q : 1'b0;
                end
            end
            default: ;
        endcase
        if (err != ERR_NONE) begin
            r.kind       = KIND_ERROR;
            r.error_code = err;
            have = 1;
            ps_q = PS_IDLE;
        end
        if (have) expected_results.push_back(r);
        if (last) clear_decoder_state();
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        in_if.in_last <= last;
        do begin
            @(posedge i_clk);
        end while (in_if.ready !== 1'b1);
        bytes_sent++;
        decode_byte(b, last);
    endtask

    task automatic send_stream;
        int gap;
        for (int i = 0; i < stream_bytes.size(); i++) begin
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
            if (src_idle_en && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 10);
                repeat (gap) begin
                    @(negedge i_clk);
                    in_if.valid <= 1'b0;
                end
            end
        end
        stream_bytes.delete();
    endtask

    task automatic wait_idle;
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header_limit(input logic [14:0] value);
        wait_idle();
        @(negedge i_clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.header_limit <= value;
        do begin
            @(posedge i_clk);
        end while (cfg_if.ready !== 1'b1);
        limit_q = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void put_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--) stream_bytes.push_back(w[8*k +: 8]);
    endfunction

    function automatic void put_header(input logic [31:0] magic, input logic [31:0] off,
                                       input logic [31:0] size, input logic [31:0] code,
                                       input logic [31:0] rate, input logic [31:0] chans);
        put_word(magic);
        put_word(off);
        put_word(size);
        put_word(code);
        put_word(rate);
        put_word(chans);
    endfunction

    function automatic void put_random(input int n);
        repeat (n) stream_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic test_sample_formats;
        logic [7:0] ulaw_pick[8] = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h0F, 8'hF0, 8'h55, 8'hAA};
        put_header(C_MAGIC_SND, 24, 8, AU_ULAW_CODE, 8000, 1);
        foreach (ulaw_pick[i]) stream_bytes.push_back(ulaw_pick[i]);
        send_stream();
        // stereo 8-bit with a skip area
        put_header(C_MAGIC_SD, 28, 6, AU_PCM8_CODE, 44100, 2);
        put_random(4);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'h80);
        stream_bytes.push_back(8'h7F);
        stream_bytes.push_back(8'h01);
        send_stream();
        // 16-bit stereo, stream ends on a high byte
        put_header(C_MAGIC_SND, 24, 32'hFFFFFFF9, AU_PCM16_CODE, 48000, 2);
        put_word(32'h80007FFF);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'h01);
        stream_bytes.push_back(8'h12);
        send_stream();
        put_header(C_MAGIC_SND, 24, 4, AU_PCM16_CODE, 32'hFFFFFFFF, 1);
        stream_bytes.push_back(8'h34);
        stream_bytes.push_back(8'h56);
        send_stream();
    endtask

    task automatic test_header_errors;
        put_word(32'h2E736E44);
        put_random(20);
        send_stream();
        put_header(C_MAGIC_SD, 23, 16, AU_PCM8_CODE, 8000, 1);
        put_random(4);
        send_stream();
        put_header(C_MAGIC_SND, 32'hFFFFFFFF, 16, AU_PCM8_CODE, 8000, 1);
        put_random(3);
        send_stream();
        put_header(C_MAGIC_SND, 24, 16, 0, 8000, 1);
        put_random(3);
        send_stream();
        put_header(C_MAGIC_SND, 24, 16, 4, 8000, 1);
        put_random(3);
        send_stream();
        put_header(C_MAGIC_SND, 24, 16, AU_ULAW_CODE, 8000, 0);
        put_random(3);
        send_stream();
        put_header(C_MAGIC_SD, 24, 16, AU_PCM16_CODE, 8000, 3);
        put_random(3);
        send_stream();
        // stream cut inside the header
        put_header(C_MAGIC_SND, 24, 16, AU_PCM8_CODE, 8000, 2);
        while (stream_bytes.size() > 10) void'(stream_bytes.pop_back());
        send_stream();
        // last transfer on the final header byte
        put_header(C_MAGIC_SND, 24, 16, AU_PCM8_CODE, 8000, 2);
        send_stream();
    endtask

    task automatic test_frame_count;
        put_header(C_MAGIC_SND, 24, 32'h80000000, AU_PCM16_CODE, 8000, 2);
        put_random(1);
        send_stream();
        put_header(C_MAGIC_SD, 24, 32'h7FFFFFFF, AU_PCM8_CODE, 11025, 2);
        put_random(2);
        send_stream();
        put_header(C_MAGIC_SND, 24, 32'hFFFFFFFF, AU_ULAW_CODE, 0, 1);
        put_random(1);
        send_stream();
        put_header(C_MAGIC_SD, 24, 32'hFFFFFFFD, AU_PCM16_CODE, 32'hFFFFFFFF, 1);
        put_random(3);
        send_stream();
    endtask

    task automatic test_limit_extremes;
        write_header_limit(15'd24);
        put_header(C_MAGIC_SND, 24, 2, AU_PCM8_CODE, 8000, 1);
        put_random(2);
        send_stream();
        put_header(C_MAGIC_SND, 25, 2, AU_PCM8_CODE, 8000, 1);
        put_random(2);
        send_stream();
        write_header_limit(15'd32767);
        put_header(C_MAGIC_SD, 32767, 2, AU_ULAW_CODE, 8000, 1);
        put_random(5);
        send_stream();
        put_header(C_MAGIC_SD, 32768, 2, AU_ULAW_CODE, 8000, 1);
        put_random(2);
        send_stream();
        write_header_limit(15'd100);
        put_header(C_MAGIC_SND, 100, 4, AU_ULAW_CODE, 8000, 2);
        put_random(76 + 4);
        send_stream();
        put_header(C_MAGIC_SND, 101, 4, AU_ULAW_CODE, 8000, 2);
        put_random(4);
        send_stream();
    endtask

    task automatic test_backpressure;
        src_idle_en   = 0;
        sink_idle_en  = 0;
        long_hold_req = 1;
        put_header(C_MAGIC_SND, 24, 200, AU_PCM8_CODE, 22050, 2);
        put_random(120);
        send_stream();
        // hold the sender until every result is out
        wait_idle();
        put_header(C_MAGIC_SD, 24, 40, AU_ULAW_CODE, 8000, 1);
        put_random(40);
        send_stream();
        wait_idle();
        src_idle_en  = 1;
        sink_idle_en = 1;
    endtask

    task automatic build_random_stream;
        logic [31:0] magic;
        logic [31:0] off;
        logic [31:0] size;
        logic [31:0] code;
        logic [31:0] chans;
        int          pick;
        int          fault;
        pick  = $urandom_range(0, 99);
        fault = -1;
        if (pick < 10) begin
            put_random($urandom_range(1, 40));
            return;
        end
        magic = $urandom_range(0, 1) ? C_MAGIC_SND : C_MAGIC_SD;
        off   = 24;
        if ($urandom_range(0, 2) != 0)
            off = 24 + $urandom_range(0, (limit_q > 64) ? 40 : int'(limit_q) - 24);
        size  = $urandom;
        code  = $urandom_range(1, 3);
        chans = $urandom_range(1, 2);
        if (pick < 25) begin
            fault = $urandom_range(0, 4);
            case (fault)
                0: magic = $urandom_range(0, 1) ? (magic ^ (32'd1 << $urandom_range(0, 31)))
                                                : $urandom;
                1: off = $urandom_range(0, 1) ? $urandom_range(0, 23)
                                              : {17'd0, limit_q} + $urandom_range(1, 3);
                2: code = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom;
                3: chans = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom;
                default: ;
            endcase
        end
        put_header(magic, off, size, code, $urandom, chans);
        if (fault == 4) begin
            // cut the header short
            while (stream_bytes.size() > $urandom_range(1, 23)) void'(stream_bytes.pop_back());
            return;
        end
        if (off > 24 && off <= 24 + 64) put_random(off - 24);
        else put_random($urandom_range(0, 3));
        put_random($urandom_range(0, 48));
    endtask

    task automatic test_random_streams(input logic [14:0] limit, input bit idle);
        int start;
        write_header_limit(limit);
        src_idle_en  = idle;
        sink_idle_en = idle;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES / 6) begin
            build_random_stream();
            send_stream();
        end
    endtask

    // result receiver: random stall bursts and one long hold-off
    initial begin
        int hold_left;
        int burst_left;
        hold_left    = 0;
        burst_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                hold_left     = LONG_HOLD;
                long_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                out_if.ready <= 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(0, 9);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // result checker
    initial begin
        t_au_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending");
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(out_if.kind), 32'(want.kind));
                    check_field("sample", 32'(out_if.sample), 32'(want.sample));
                    check_field("channel", 32'(out_if.channel), 32'(want.channel));
                    check_field("encoding", 32'(out_if.encoding), 32'(want.encoding));
                    check_field("sample_rate", out_if.sample_rate, want.sample_rate);
                    check_field("channels", 32'(out_if.channels), 32'(want.channels));
                    check_field("frame_count", out_if.frame_count, want.frame_count);
                    check_field("data_offset", out_if.data_offset, want.data_offset);
                    check_field("error_code", 32'(out_if.error_code),
                                32'(want.error_code));
                end
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        in_if.valid         = 1'b0;
        in_if.in_byte       = '0;
        in_if.in_last       = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.header_limit = C_HEADER_LIMIT_RESET;
        i_rst_n             = 1'b0;
        mismatches          = 0;
        bytes_sent          = 0;
        src_idle_en         = 1;
        sink_idle_en        = 1;
        long_hold_req       = 0;
        limit_q             = C_HEADER_LIMIT_RESET;
        clear_decoder_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_sample_formats();
        test_header_errors();
        test_frame_count();
        test_limit_extremes();
        test_backpressure();
        test_random_streams(15'd32767, 1);
        test_random_streams(15'd24, 1);
        test_random_streams(15'($urandom_range(24, 32767)), 1);
        test_random_streams(15'd60, 1);
        test_random_streams(15'($urandom_range(24, 32767)), 1);
        test_random_streams(15'd32767, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
